>>> hw/rtl/xtea_pkg.sv
// XTEA package: lane and key types, the round constant and the mixing function.
// Used by xtea_round_cell and xtea_block_encrypt_decrypt_core; no dependencies.
package xtea_pkg;

   localparam logic [31:0] XTEA_DELTA = 32'h9E37_79B9;
   localparam int unsigned KEY_WORDS  = 4;
   localparam int unsigned CSR_INDEX_W = 8;

   typedef enum logic {
      OP_ENCRYPT = 1'b0,
      OP_DECRYPT = 1'b1
   } opcode_type;

   typedef logic [KEY_WORDS-1:0][31:0] key_type;

   // One block in flight between pipeline stages
   typedef struct packed {
      logic       valid;
      opcode_type op;
      logic [31:0] v0;
      logic [31:0] v1;
   } lane_type;

   // ((v << 4) ^ (v >> 5)) + v, modulo 2^32
   function automatic logic [31:0] xtea_mix(input logic [31:0] v);
      return ({v[27:0], 4'b0000} ^ {5'b00000, v[31:5]}) + v;
   endfunction

endpackage

>>> hw/rtl/xtea_block_encrypt_decrypt_core.sv
// XTEA encrypt/decrypt core: key registers and a chain of CYCLES round cells.
// Depends on xtea_pkg and xtea_round_cell.
//
// Usage:
//  - Load the 128-bit key through the csr_ port (index 0..3, one word per
//    write); writes to other indexes are dropped. Change the key only while
//    no block is in flight.
//  - Present a block on req_block_high/req_block_low with req_opcode
//    (0 encrypt, 1 decrypt); a transfer happens when req_valid is high and
//    req_stall is low.
//  - Each round cell performs one full XTEA cycle over two register stages,
//    so a block passes both stages of every cell on its way out. The chain
//    takes one block per clock, one result per clock, while not held (below).
//  - The last stage of the chain is the output register. While rsp_valid is
//    high and rsp_stall is high the whole chain holds and req_stall is high;
//    nothing is lost or repeated.
//  - Reset clears the key words to zero and empties the chain.
module xtea_block_encrypt_decrypt_core #(
   parameter int unsigned CYCLES = 32
) (
   input  logic                             clock,
   input  logic                             reset,
   // configuration writes
   input  logic                             csr_wr_en,
   input  logic [xtea_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [31:0]                      csr_wr_data,
   // input blocks
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [31:0]                      req_block_high,
   input  logic [31:0]                      req_block_low,
   input  logic                             req_opcode,
   // result blocks
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [31:0]                      rsp_out_high,
   output logic [31:0]                      rsp_out_low
);
   import xtea_pkg::*;

   key_type  key_ff;
   lane_type lane [0:CYCLES];
   logic     advance;

   // Key words; writes beyond the last word are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_wr_en && (csr_index < CSR_INDEX_W'(KEY_WORDS))) begin
         key_ff[csr_index[1:0]] <= csr_wr_data;
      end
   end

   // Whole chain moves unless a finished result is held at the output
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   // Head of the chain takes the transfer directly
   always_comb begin
      lane[0].valid = req_valid;
      lane[0].op    = opcode_type'(req_opcode);
      lane[0].v0    = req_block_high;
      lane[0].v1    = req_block_low;
   end

   for (genvar i = 0; i < CYCLES; i++) begin : g_cell
      xtea_round_cell #(
         .CYCLES (CYCLES),
         .IDX    (i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .key      (key_ff),
         .lane_in  (lane[i]),
         .lane_out (lane[i+1])
      );
   end

   assign rsp_valid    = lane[CYCLES].valid;
   assign rsp_out_high = lane[CYCLES].v0;
   assign rsp_out_low  = lane[CYCLES].v1;

endmodule

>>> hw/rtl/xtea_round_cell.sv
// XTEA round cell: one full cycle (two half-rounds) over two register stages.
// Depends on xtea_pkg; the round sums are fixed per cell from its position.
module xtea_round_cell #(
   parameter int unsigned CYCLES = 32,
   parameter int unsigned IDX    = 0
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  xtea_pkg::key_type key,
   input  xtea_pkg::lane_type lane_in,
   output xtea_pkg::lane_type lane_out
);
   import xtea_pkg::*;

   // Round sums of this cell for each direction
   localparam logic [31:0] ENC_SUM_A = 32'(64'(XTEA_DELTA) * 64'(IDX));
   localparam logic [31:0] ENC_SUM_B = 32'(64'(XTEA_DELTA) * 64'(IDX + 1));
   localparam logic [31:0] DEC_SUM_A = 32'(64'(XTEA_DELTA) * 64'(CYCLES - IDX));
   localparam logic [31:0] DEC_SUM_B = 32'(64'(XTEA_DELTA) * 64'(CYCLES - IDX - 1));
   localparam logic [1:0]  ENC_KEY_A = ENC_SUM_A[1:0];
   localparam logic [1:0]  ENC_KEY_B = ENC_SUM_B[12:11];
   localparam logic [1:0]  DEC_KEY_A = DEC_SUM_A[12:11];
   localparam logic [1:0]  DEC_KEY_B = DEC_SUM_B[1:0];

   lane_type    mid_ff, mid_in;
   lane_type    out_ff, out_in;
   logic [31:0] a_src, a_tgt, a_rk, a_f, a_new;
   logic [31:0] b_src, b_tgt, b_rk, b_f, b_new;
   logic        a_dec, b_dec;

   // First half-round: encrypt updates v0, decrypt updates v1
   always_comb begin
      a_dec  = (lane_in.op == OP_DECRYPT);
      a_src  = a_dec ? lane_in.v0 : lane_in.v1;
      a_tgt  = a_dec ? lane_in.v1 : lane_in.v0;
      a_rk   = a_dec ? (DEC_SUM_A + key[DEC_KEY_A]) : (ENC_SUM_A + key[ENC_KEY_A]);
      a_f    = xtea_mix(a_src) ^ a_rk;
      a_new  = a_dec ? (a_tgt - a_f) : (a_tgt + a_f);
      mid_in = lane_in;
      if (a_dec) begin
         mid_in.v1 = a_new;
      end else begin
         mid_in.v0 = a_new;
      end
   end

   // Second half-round: encrypt updates v1, decrypt updates v0
   always_comb begin
      b_dec  = (mid_ff.op == OP_DECRYPT);
      b_src  = b_dec ? mid_ff.v1 : mid_ff.v0;
      b_tgt  = b_dec ? mid_ff.v0 : mid_ff.v1;
      b_rk   = b_dec ? (DEC_SUM_B + key[DEC_KEY_B]) : (ENC_SUM_B + key[ENC_KEY_B]);
      b_f    = xtea_mix(b_src) ^ b_rk;
      b_new  = b_dec ? (b_tgt - b_f) : (b_tgt + b_f);
      out_in = mid_ff;
      if (b_dec) begin
         out_in.v0 = b_new;
      end else begin
         out_in.v1 = b_new;
      end
   end

   // Valid bits: clear on reset, move with the chain
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_ff.valid <= 1'b0;
         out_ff.valid <= 1'b0;
      end else if (advance) begin
         mid_ff.valid <= mid_in.valid;
         out_ff.valid <= out_in.valid;
      end
   end

   // Payload: advance with the chain, hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff.op <= mid_in.op;
         mid_ff.v0 <= mid_in.v0;
         mid_ff.v1 <= mid_in.v1;
         out_ff.op <= out_in.op;
         out_ff.v0 <= out_in.v0;
         out_ff.v1 <= out_in.v1;
      end
   end

   assign lane_out = out_ff;

endmodule

>>> tb/tb.sv
// Self-checking testbench for xtea_block_encrypt_decrypt_core: XTEA encrypt and decrypt
// under several keys, with random idling on both channels. Depends on xtea_pkg and the RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import xtea_pkg::*;

   localparam int unsigned ROUNDS         = 32;
   localparam int unsigned HALF_PERIOD    = 10;
   localparam logic [31:0] ROUND_CONST    = 32'h9E37_79B9;
   localparam int unsigned WATCHDOG_LIMIT = 1000;
   localparam int unsigned RANDOM_PHASES  = 6;
   localparam int unsigned PHASE_ITEMS    = 255;
   localparam int unsigned DRAIN_CYCLES   = 2 * ROUNDS + 8;
   localparam int unsigned DIRECTED_ROWS  = 12;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_KEY_WORD_0 = 0,
      CSR_KEY_WORD_1 = 1,
      CSR_KEY_WORD_2 = 2,
      CSR_KEY_WORD_3 = 3
   } csr_reg_type;

   localparam logic [CSR_INDEX_W-1:0] CSR_INDEX_MAX = '1;

   typedef struct packed {
      logic [31:0] high;
      logic [31:0] low;
   } block_type;

   typedef struct packed {
      logic [31:0] high;
      logic [31:0] low;
      opcode_type  op;
   } stim_row_type;

   logic                   clock          = 1'b0;
   logic                   reset          = 1'b1;
   logic                   csr_wr_en      = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index      = '0;
   logic [31:0]            csr_wr_data    = '0;
   logic                   req_valid      = 1'b0;
   logic                   req_stall;
   logic [31:0]            req_block_high = '0;
   logic [31:0]            req_block_low  = '0;
   logic                   req_opcode     = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall      = 1'b0;
   logic [31:0]            rsp_out_high;
   logic [31:0]            rsp_out_low;

   // key words as the core should hold them
   logic [31:0] key_shadow [KEY_WORDS];
   // cipher outputs owed by the core, oldest first
   block_type   pending_cipher_out [$];
   int unsigned error_count  = 0;
   int unsigned quiet_cycles = 0;
   int unsigned gap_chance   = 0;
   int unsigned stall_chance = 0;
   int unsigned stall_left   = 0;

   // Cipher output cannot be read off by eye, so every row is checked by the predictor
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 32'h0000_0000, OP_ENCRYPT},
      '{32'h0000_0000, 32'h0000_0000, OP_DECRYPT},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_ENCRYPT},
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, OP_DECRYPT},
      '{32'h8000_0000, 32'h0000_0001, OP_ENCRYPT},
      '{32'h0000_0001, 32'h8000_0000, OP_DECRYPT},
      '{32'hAAAA_AAAA, 32'h5555_5555, OP_ENCRYPT},
      '{32'h5555_5555, 32'hAAAA_AAAA, OP_DECRYPT},
      '{32'hFFFF_FFFF, 32'h0000_0000, OP_ENCRYPT},
      '{32'h0000_0000, 32'hFFFF_FFFF, OP_DECRYPT},
      '{32'h0123_4567, 32'h89AB_CDEF, OP_ENCRYPT},
      '{32'h89AB_CDEF, 32'h0123_4567, OP_DECRYPT}
   };

   xtea_block_encrypt_decrypt_core #(
      .CYCLES(ROUNDS)
   ) u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_block_high (req_block_high),
      .req_block_low  (req_block_low),
      .req_opcode     (req_opcode),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_high   (rsp_out_high),
      .rsp_out_low    (rsp_out_low)
   );

   always #HALF_PERIOD clock = ~clock;

   // XTEA round function on one half
   function automatic logic [31:0] half_scramble(input logic [31:0] v);
      return ((v << 4) ^ (v >> 5)) + v;
   endfunction

   // Full XTEA encryption or decryption under the shadow key
   function automatic block_type xtea_transform(input logic [31:0] high,
                                                input logic [31:0] low,
                                                input opcode_type op);
      logic [31:0] v0;
      logic [31:0] v1;
      logic [31:0] sum;
      block_type   result;
      v0 = high;
      v1 = low;
      if (op == OP_ENCRYPT) begin
         sum = '0;
         for (int unsigned i = 0; i < ROUNDS; i++) begin
            v0  = v0 + (half_scramble(v1) ^ (sum + key_shadow[sum[1:0]]));
            sum = sum + ROUND_CONST;
            v1  = v1 + (half_scramble(v0) ^ (sum + key_shadow[sum[12:11]]));
         end
      end else begin
         sum = ROUND_CONST * ROUNDS;
         for (int unsigned i = 0; i < ROUNDS; i++) begin
            v1  = v1 - (half_scramble(v0) ^ (sum + key_shadow[sum[12:11]]));
            sum = sum - ROUND_CONST;
            v0  = v0 - (half_scramble(v1) ^ (sum + key_shadow[sum[1:0]]));
         end
      end
      result.high = v0;
      result.low  = v1;
      return result;
   endfunction

   // Mix of extremes, single bits and plain random words
   function automatic logic [31:0] pick_word();
      unique case ($urandom_range(0, 7))
         0: return '0;
         1: return '1;
         2: return 32'h1 << $urandom_range(0, 31);
         3: return ~(32'h1 << $urandom_range(0, 31));
         default: return $urandom;
      endcase
   endfunction

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] index, input logic [31:0] data);
      csr_wr_en   <= 1'b1;
      csr_index   <= index;
      csr_wr_data <= data;
      @(posedge clock);
      if (index < KEY_WORDS) begin
         key_shadow[index[1:0]] = data;
      end
   endtask

   // Load all four key words, then hit unmapped indexes that must be dropped
   task automatic load_key(input key_type key);
      csr_write(CSR_KEY_WORD_0, key[0]);
      csr_write(CSR_KEY_WORD_1, key[1]);
      csr_write(CSR_KEY_WORD_2, key[2]);
      csr_write(CSR_KEY_WORD_3, key[3]);
      csr_write(CSR_INDEX_W'($urandom_range(KEY_WORDS, CSR_INDEX_MAX)), $urandom);
      csr_write(CSR_INDEX_MAX, $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // Present one block, with an optional gap first, and hold it until the transfer
   task automatic send_block(input logic [31:0] high, input logic [31:0] low,
                             input opcode_type op);
      if (gap_chance != 0 && $urandom_range(1, 100) <= gap_chance) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_block_high <= high;
      req_block_low  <= low;
      req_opcode     <= op;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_cipher_out.size() != 0) @(posedge clock);
   endtask

   // Result-side stall bursts
   always @(posedge clock) begin
      if (reset || stall_chance == 0) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         rsp_stall  <= 1'b1;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(1, 100) <= stall_chance) begin
         rsp_stall  <= 1'b1;
         stall_left <= $urandom_range(0, 8);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Predict on each input transfer, compare on each result transfer, watch for a hang
   always @(posedge clock) begin : scoreboard
      block_type want;
      logic      moved;
      moved = 1'b0;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_cipher_out.push_back(
               xtea_transform(req_block_high, req_block_low, opcode_type'(req_opcode)));
            moved = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (pending_cipher_out.size() == 0) begin
               $display("%0t: unexpected result %h %h", $time, rsp_out_high, rsp_out_low);
               error_count++;
            end else begin
               want = pending_cipher_out.pop_front();
               if (rsp_out_high !== want.high) begin
                  $display("%0t: out_high mismatch: expected %h, actual %h",
                           $time, want.high, rsp_out_high);
                  error_count++;
               end
               if (rsp_out_low !== want.low) begin
                  $display("%0t: out_low mismatch: expected %h, actual %h",
                           $time, want.low, rsp_out_low);
                  error_count++;
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   initial begin
      key_type     key;
      logic [31:0] high;
      logic [31:0] low;
      opcode_type  op;
      block_type   turned;
      int          items_left;

      foreach (key_shadow[i]) key_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed rows: first under the reset key, then under the all-ones key
      gap_chance   = 25;
      stall_chance = 25;
      for (int pass = 0; pass < 2; pass++) begin
         if (pass == 1) begin
            wait_drained();
            load_key('1);
         end
         for (int r = 0; r < DIRECTED_ROWS; r++) begin
            send_block(directed_rows[r].high, directed_rows[r].low, directed_rows[r].op);
         end
      end

      // Random phases, one key each; the last phase runs without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         for (int w = 0; w < KEY_WORDS; w++) key[w] = pick_word();
         load_key(key);
         if (phase == RANDOM_PHASES - 1) begin
            gap_chance   = 0;
            stall_chance = 0;
         end else begin
            gap_chance   = $urandom_range(0, 3) * 15;
            stall_chance = $urandom_range(0, 3) * 15;
         end
         items_left = PHASE_ITEMS;
         while (items_left > 0) begin
            high = pick_word();
            low  = pick_word();
            op   = opcode_type'($urandom_range(0, 1));
            send_block(high, low, op);
            items_left--;
            // feed the result back the other way half the time: must give the block back
            if (items_left > 0 && $urandom_range(0, 1) == 1) begin
               turned = xtea_transform(high, low, op);
               send_block(turned.high, turned.low, opcode_type'(~op));
               items_left--;
            end
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_cipher_out.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/xtea_pkg.sv
hw/rtl/xtea_round_cell.sv
hw/rtl/xtea_block_encrypt_decrypt_core.sv
tb/tb.sv
